@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the clocked assertions of the execute block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define RME_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("execute block assertion failed");

// The expression must never be true at a clock edge outside reset.
`define RME_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("execute block forbidden condition seen");

`endif

@@ design/rme_pkg.sv @@
// ----------------------------------------------------------------------------
// rme_pkg
// Shared constants of the register machine execute block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rme_pkg;

	localparam int REG_COUNT_DEF = 16;
	localparam int MEM_WORDS_DEF = 256;
	localparam int DATA_W        = 32;

	localparam int TYPE_W = 4;
	localparam int REGI_W = 8;
	localparam int OPB_W  = 10;
	localparam int OPC_W  = 8;
	localparam int ERR_W  = 2;

	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 40;

	localparam int SET_SHIFT = 4;
	localparam int DIV_STEPS = 32;
	localparam int DIVC_W    = $clog2(DIV_STEPS);

	localparam logic [TYPE_W-1:0] OP_ADD   = 4'd0;
	localparam logic [TYPE_W-1:0] OP_MUL   = 4'd1;
	localparam logic [TYPE_W-1:0] OP_DIV   = 4'd2;
	localparam logic [TYPE_W-1:0] OP_SUB   = 4'd3;
	localparam logic [TYPE_W-1:0] OP_LOAD  = 4'd4;
	localparam logic [TYPE_W-1:0] OP_SAVE  = 4'd5;
	localparam logic [TYPE_W-1:0] OP_PRINT = 4'd6;
	localparam logic [TYPE_W-1:0] OP_STORE = 4'd7;
	localparam logic [TYPE_W-1:0] OP_SET   = 4'd8;

	localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
	localparam logic [ERR_W-1:0] ERR_BOUNDS  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_DIVZERO = 2'd2;
	localparam logic [ERR_W-1:0] ERR_UNDEF   = 2'd3;

endpackage

@@ design/rme_ram.sv @@
// ----------------------------------------------------------------------------
// rme_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rme_ram #(
	parameter int WIDTH = rme_pkg::DATA_W,
	parameter int DEPTH = rme_pkg::REG_COUNT_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ design/register_machine_execute.sv @@
// ----------------------------------------------------------------------------
// register_machine_execute
// Executes one decoded instruction per item against a register file and a
// data memory and returns the affected register value with an error code.
// ----------------------------------------------------------------------------
// After reset the block clears both memories, one entry per cycle, over
// max(REG_COUNT, MEM_WORDS) entries, and accepts no item until that is done.
// Each instruction then passes ST_RDA, ST_RDB, ST_WB and ST_DONE on its way to
// the output register: the register file is read twice through its single read
// port, and any result is written back before it is presented. Instructions
// rejected at acceptance go straight to ST_DONE, a zero divisor skips ST_WB,
// and a divide adds ST_DIV, forming the quotient one bit per cycle, and ST_SIGN.
// The next item is accepted once the previous result has entered the output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module register_machine_execute #(
	parameter int REG_COUNT = rme_pkg::REG_COUNT_DEF,
	parameter int MEM_WORDS = rme_pkg::MEM_WORDS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// req_type[3:0], reg_index[11:4], operand_b[21:12], operand_c[29:22], zero.
	input  logic [rme_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// result_value[31:0], error_code[33:32], zero.
	output logic [rme_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

	localparam int RW    = $clog2(REG_COUNT);
	localparam int AW    = $clog2(MEM_WORDS);
	localparam int CLR_N = (REG_COUNT > MEM_WORDS) ? REG_COUNT : MEM_WORDS;
	localparam int CW    = $clog2(CLR_N);
	localparam int DW    = rme_pkg::DATA_W;

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_RDA   = 8'b0000_0100,
		ST_RDB   = 8'b0000_1000,
		ST_DIV   = 8'b0001_0000,
		ST_SIGN  = 8'b0010_0000,
		ST_WB    = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t st_q;
	logic [CW-1:0] clr_q;
	logic out_vld_q;

	logic [rme_pkg::TYPE_W-1:0] in_type;
	logic [rme_pkg::REGI_W-1:0] in_r;
	logic [rme_pkg::OPB_W-1:0]  in_b;
	logic [rme_pkg::OPC_W-1:0]  in_c;
	logic [rme_pkg::ERR_W-1:0]  in_err;
	logic accept;

	logic [rme_pkg::TYPE_W-1:0] op_q;
	logic [rme_pkg::REGI_W-1:0] r_q;
	logic [rme_pkg::OPB_W-1:0]  b_q;
	logic [rme_pkg::OPC_W-1:0]  c_q;
	logic [rme_pkg::ERR_W-1:0]  err_q;
	logic [DW-1:0] x_q;
	logic [DW-1:0] val_q;
	logic wb_q;

	logic [DW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic neg_q;
	logic [rme_pkg::DIVC_W-1:0] dcnt_q;
	logic [DW:0] div_shift;
	logic [DW:0] div_diff;

	logic [DW-1:0] out_val_q;
	logic [rme_pkg::ERR_W-1:0] out_err_q;

	logic          rf_we;
	logic [RW-1:0] rf_waddr;
	logic [DW-1:0] rf_wdata;
	logic [RW-1:0] rf_raddr;
	logic [DW-1:0] rf_rdata;
	logic          dm_we;
	logic [AW-1:0] dm_waddr;
	logic [DW-1:0] dm_wdata;
	logic [DW-1:0] dm_rdata;

	assign in_type = s_axis_tdata[3:0];
	assign in_r    = s_axis_tdata[11:4];
	assign in_b    = s_axis_tdata[21:12];
	assign in_c    = s_axis_tdata[29:22];

	assign s_axis_tready = (st_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		in_err = rme_pkg::ERR_OK;
		if (in_type > rme_pkg::OP_SET) begin
			in_err = rme_pkg::ERR_UNDEF;
		end else if (32'(in_r) >= 32'(REG_COUNT)) begin
			in_err = rme_pkg::ERR_BOUNDS;
		end else if (in_type <= rme_pkg::OP_SUB && 32'(in_b) >= 32'(REG_COUNT)) begin
			in_err = rme_pkg::ERR_BOUNDS;
		end else if ((in_type == rme_pkg::OP_LOAD || in_type == rme_pkg::OP_SAVE ||
				in_type == rme_pkg::OP_STORE) && 32'(in_b) >= 32'(MEM_WORDS)) begin
			in_err = rme_pkg::ERR_BOUNDS;
		end
	end

	assign rf_raddr = (st_q == ST_IDLE) ? in_r[RW-1:0] : b_q[RW-1:0];
	assign rf_we    = (st_q == ST_CLEAR) || (st_q == ST_WB && wb_q);
	assign rf_waddr = (st_q == ST_CLEAR) ? clr_q[RW-1:0] : r_q[RW-1:0];
	assign rf_wdata = (st_q == ST_CLEAR) ? '0 : val_q;

	assign dm_we    = (st_q == ST_CLEAR) ||
		(st_q == ST_RDB && (op_q == rme_pkg::OP_SAVE || op_q == rme_pkg::OP_STORE));
	assign dm_waddr = (st_q == ST_CLEAR) ? clr_q[AW-1:0] : b_q[AW-1:0];
	assign dm_wdata = (st_q == ST_CLEAR) ? '0 : x_q;

	rme_ram #(
		.WIDTH(DW),
		.DEPTH(REG_COUNT)
	) u_regfile (
		.clk(clk),
		.wr_en(rf_we),
		.wr_addr(rf_waddr),
		.wr_data(rf_wdata),
		.rd_addr(rf_raddr),
		.rd_data(rf_rdata)
	);

	rme_ram #(
		.WIDTH(DW),
		.DEPTH(MEM_WORDS)
	) u_datamem (
		.clk(clk),
		.wr_en(dm_we),
		.wr_addr(dm_waddr),
		.wr_data(dm_wdata),
		.rd_addr(b_q[AW-1:0]),
		.rd_data(dm_rdata)
	);

	assign div_shift = {rem_q, quo_q[DW-1]};
	assign div_diff  = div_shift - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_CLEAR;
			clr_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (st_q == ST_DONE && (!out_vld_q || m_axis_tready)) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CW'(CLR_N - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						st_q <= (in_err != rme_pkg::ERR_OK) ? ST_DONE : ST_RDA;
					end
				end
				ST_RDA: begin
					st_q <= ST_RDB;
				end
				ST_RDB: begin
					if (op_q == rme_pkg::OP_DIV) begin
						st_q <= (rf_rdata == '0) ? ST_DONE : ST_DIV;
					end else begin
						st_q <= ST_WB;
					end
				end
				ST_DIV: begin
					if (dcnt_q == rme_pkg::DIVC_W'(rme_pkg::DIV_STEPS - 1)) begin
						st_q <= ST_SIGN;
					end
				end
				ST_SIGN: begin
					st_q <= ST_WB;
				end
				ST_WB: begin
					st_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_vld_q || m_axis_tready) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				op_q  <= in_type;
				r_q   <= in_r;
				b_q   <= in_b;
				c_q   <= in_c;
				err_q <= in_err;
				val_q <= '0;
				wb_q  <= 1'b0;
			end
			ST_RDA: begin
				x_q <= rf_rdata;
			end
			ST_RDB: begin
				case (op_q)
					rme_pkg::OP_ADD: begin
						val_q <= x_q + rf_rdata;
						wb_q  <= 1'b1;
					end
					rme_pkg::OP_SUB: begin
						val_q <= x_q - rf_rdata;
						wb_q  <= 1'b1;
					end
					rme_pkg::OP_MUL: begin
						val_q <= x_q * rf_rdata;
						wb_q  <= 1'b1;
					end
					rme_pkg::OP_LOAD: begin
						val_q <= dm_rdata;
						wb_q  <= 1'b1;
					end
					rme_pkg::OP_STORE: begin
						val_q <= '0;
						wb_q  <= 1'b1;
					end
					rme_pkg::OP_SET: begin
						val_q <= (DW'(b_q) << rme_pkg::SET_SHIFT) + DW'(c_q);
						wb_q  <= 1'b1;
					end
					rme_pkg::OP_DIV: begin
						val_q  <= '0;
						wb_q   <= 1'b0;
						neg_q  <= x_q[DW-1] ^ rf_rdata[DW-1];
						quo_q  <= x_q[DW-1] ? (DW'(0) - x_q) : x_q;
						dvs_q  <= rf_rdata[DW-1] ? (DW'(0) - rf_rdata) : rf_rdata;
						rem_q  <= '0;
						dcnt_q <= '0;
						if (rf_rdata == '0) begin
							err_q <= rme_pkg::ERR_DIVZERO;
						end
					end
					default: begin
						val_q <= x_q;
						wb_q  <= 1'b0;
					end
				endcase
			end
			ST_DIV: begin
				dcnt_q <= dcnt_q + 1'b1;
				quo_q  <= {quo_q[DW-2:0], ~div_diff[DW]};
				rem_q  <= div_diff[DW] ? div_shift[DW-1:0] : div_diff[DW-1:0];
			end
			ST_SIGN: begin
				val_q <= neg_q ? (DW'(0) - quo_q) : quo_q;
				wb_q  <= 1'b1;
			end
			ST_DONE: begin
				if (!out_vld_q || m_axis_tready) begin
					out_val_q <= val_q;
					out_err_q <= err_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {6'd0, out_err_q, out_val_q};

	`RME_ASSERT(a_err_zero_value, m_axis_tvalid && m_axis_tdata[33:32] != rme_pkg::ERR_OK |-> m_axis_tdata[31:0] == '0)
	`RME_ASSERT(a_wb_in_range, st_q == ST_WB && wb_q |-> 32'(r_q) < 32'(REG_COUNT))
	`RME_ASSERT(a_div_ends, st_q == ST_DIV && dcnt_q == rme_pkg::DIVC_W'(rme_pkg::DIV_STEPS - 1) |=> st_q == ST_SIGN)
	`RME_NEVER(a_dm_write_err, st_q == ST_RDB && dm_we && err_q != rme_pkg::ERR_OK)

endmodule
